[design/lil_pkg.sv]
// shared types and codes for the indexed list block
package lil_pkg;

   localparam int CAPACITY_DEFAULT = 16;

   localparam int CMD_W    = 3;
   localparam int POS_W    = 5;
   localparam int WORD_W   = 32;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   typedef enum logic [2:0] {
      DP_NOP,
      DP_APPEND,
      DP_INSERT,
      DP_POP,
      DP_ERASE,
      DP_READ
   } dp_op_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_EXEC,
      CTL_RESP
   } ctl_state_type;

   typedef struct packed {
      logic                capture;
      logic                execute;
      dp_op_type           op;
      logic [STATUS_W-1:0] status;
   } dp_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             full;
      logic             empty;
      logic             pos_gt_count;
      logic             pos_ge_count;
   } dp_stat_type;

endpackage

[design/lil_ctrl.sv]
// controller: request handshake, command decode and response handshake
module lil_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  lil_pkg::dp_stat_type stat,
   output lil_pkg::dp_cmd_type  cmd
);
   import lil_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_IDLE: begin
            if (req_tvalid) state_in = CTL_EXEC;
         end
         CTL_EXEC: begin
            state_in = CTL_RESP;
         end
         CTL_RESP: begin
            if (rsp_tready) state_in = CTL_IDLE;
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      cmd.op      = DP_NOP;
      cmd.status  = ST_OK;
      case (state_ff)
         CTL_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         CTL_EXEC: begin
            cmd.execute = 1'b1;
            case (stat.cmd)
               CMD_APPEND: begin
                  if (stat.full) cmd.status = ST_FULL;
                  else cmd.op = DP_APPEND;
               end
               CMD_INSERT: begin
                  // fullness wins over a bad position
                  if (stat.full) cmd.status = ST_FULL;
                  else if (stat.pos_gt_count) cmd.status = ST_RANGE;
                  else cmd.op = DP_INSERT;
               end
               CMD_POP: begin
                  if (stat.empty) cmd.status = ST_EMPTY;
                  else cmd.op = DP_POP;
               end
               CMD_ERASE: begin
                  if (stat.pos_ge_count) cmd.status = ST_RANGE;
                  else cmd.op = DP_ERASE;
               end
               CMD_READ: begin
                  if (stat.pos_ge_count) cmd.status = ST_RANGE;
                  else cmd.op = DP_READ;
               end
               default: begin
                  cmd.op = DP_NOP;
               end
            endcase
         end
         CTL_RESP: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

[design/lil_datapath.sv]
// datapath: shifting cell chain, entry count, request and response registers
module lil_datapath #(
   parameter int CAPACITY = lil_pkg::CAPACITY_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lil_pkg::CMD_W-1:0]     req_cmd,
   input  logic [lil_pkg::POS_W-1:0]     req_position,
   input  logic [lil_pkg::WORD_W-1:0]    req_value,
   input  lil_pkg::dp_cmd_type           cmd,
   output lil_pkg::dp_stat_type          stat,
   output logic [lil_pkg::WORD_W-1:0]    rsp_read_data,
   output logic [lil_pkg::COUNT_W-1:0]   rsp_entry_count,
   output logic [lil_pkg::STATUS_W-1:0]  rsp_status
);
   import lil_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_A = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int CMP_W = (CMP_A > COUNT_W) ? CMP_A : COUNT_W;
   localparam logic [CMP_W-1:0] CAP_EXT = CMP_W'(CAPACITY);

   logic [WORD_W-1:0]   entries_ff [CAPACITY];
   logic [WORD_W-1:0]   entries_in [CAPACITY];
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CMD_W-1:0]    cmd_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [WORD_W-1:0]   value_ff;
   logic [WORD_W-1:0]   read_ff, read_in;
   logic [COUNT_W-1:0]  rcount_ff;
   logic [STATUS_W-1:0] status_ff;

   logic [CMP_W-1:0] count_ext, pos_ext, ins_pos;
   logic             do_ins, do_erase;

   assign count_ext = CMP_W'(count_ff);
   assign pos_ext   = CMP_W'(pos_ff);
   assign ins_pos   = (cmd.op == DP_APPEND) ? count_ext : pos_ext;
   assign do_ins    = (cmd.op == DP_APPEND) || (cmd.op == DP_INSERT);
   assign do_erase  = (cmd.op == DP_ERASE);

   assign stat.cmd          = cmd_ff;
   assign stat.full         = (count_ext >= CAP_EXT);
   assign stat.empty        = (count_ff == '0);
   assign stat.pos_gt_count = (pos_ext > count_ext);
   assign stat.pos_ge_count = (pos_ext >= count_ext);

   // every cell picks its own next word from itself, a neighbor or the request value
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WORD_W-1:0] below_word, above_word;
      if (i == 0) begin : g_first
         assign below_word = entries_ff[0];
      end else begin : g_below
         assign below_word = entries_ff[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign above_word = entries_ff[i];
      end else begin : g_above
         assign above_word = entries_ff[i+1];
      end
      always_comb begin
         entries_in[i] = entries_ff[i];
         if (do_ins && (CMP_W'(i) == ins_pos)) begin
            entries_in[i] = value_ff;
         end else if (do_ins && (CMP_W'(i) > ins_pos) && (CMP_W'(i) <= count_ext)) begin
            entries_in[i] = below_word;
         end else if (do_erase && (CMP_W'(i) >= pos_ext)
                      && (CMP_W'(i + 1) < count_ext)) begin
            entries_in[i] = above_word;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      read_in  = '0;
      case (cmd.op)
         DP_APPEND, DP_INSERT: count_in = count_ff + CNT_W'(1);
         DP_POP, DP_ERASE:     count_in = count_ff - CNT_W'(1);
         DP_READ:              read_in  = entries_ff[IDX_W'(pos_ext)];
         default:              count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff   <= req_cmd;
         pos_ff   <= req_position;
         value_ff <= req_value;
      end
      if (cmd.execute) begin
         entries_ff <= entries_in;
         read_ff    <= read_in;
         rcount_ff  <= COUNT_W'(CMP_W'(count_in));
         status_ff  <= cmd.status;
      end
   end

   assign rsp_read_data   = read_ff;
   assign rsp_entry_count = rcount_ff;
   assign rsp_status      = status_ff;

endmodule

[design/indexed_list_insert_erase_top.sv]
// top level of the indexed list insert/erase block
// Ordered list of up to CAPACITY signed 32-bit words. Each request carries one
// command (append, insert at position, remove last, erase at position, read)
// and returns one response with the word read, the entry count after the step
// and a status code. A request is accepted in the idle state and executes on
// the next cycle; its response is valid the cycle after execution and is held
// until taken. A request passes through accept, execute and response; one
// request is in flight at a time, and the next request is taken the cycle
// after the response is accepted.
// Insert and erase shift the affected cells of the chain in parallel in the execute
// cycle. List contents are not cleared at reset; only the count is.
module indexed_list_insert_erase_top #(
   parameter int CAPACITY = lil_pkg::CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // cmd[2:0], position[7:3], value[39:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // read_data[31:0], entry_count[36:32], status[38:37]
);
   import lil_pkg::*;

   dp_cmd_type          cmd;
   dp_stat_type         stat;
   logic [WORD_W-1:0]   read_data;
   logic [COUNT_W-1:0]  entry_count;
   logic [STATUS_W-1:0] status;

   lil_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   lil_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_tdata[2:0]),
      .req_position    (req_tdata[7:3]),
      .req_value       (req_tdata[39:8]),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_read_data   (read_data),
      .rsp_entry_count (entry_count),
      .rsp_status      (status)
   );

   assign rsp_tdata = {1'b0, status, entry_count, read_data};

endmodule

[tb/sv/indexed_list_insert_erase_top_tb.sv]
`timescale 1ns / 1ps
// testbench for the indexed list block: table-driven and random requests checked against a predictor
module indexed_list_insert_erase_top_tb;
   import lil_pkg::*;

   localparam int DEPTH       = CAPACITY_DEFAULT;
   localparam int QUIET_LIMIT = 2000;
   localparam int RAND_ITEMS  = 120;

   // command codes the block treats as no-ops
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic [POS_W-1:0]  pos;
      logic [CMD_W-1:0]  cmd;
   } list_req_t;

   typedef struct packed {
      logic                       pad;
      logic [STATUS_W-1:0]        status;
      logic [COUNT_W-1:0]         count;
      logic signed [WORD_W-1:0]   rdata;
   } list_rsp_t;

   typedef struct {
      list_req_t req;
      int        reps;
      bit        typed;
      list_rsp_t want;
   } dir_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // cmd[2:0], position[7:3], value[39:8]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // read_data[31:0], entry_count[36:32], status[38:37]

   // predictor state
   logic [WORD_W-1:0] list_words [DEPTH];
   int                list_len = 0;
   bit                filling = 1'b1;

   list_rsp_t pending_rsp [$];
   dir_row_t  dir_rows [$];
   int        mismatches = 0;
   int        send_idle_pct = 0;
   int        stall_pct = 0;
   int        quiet_cycles = 0;

   indexed_list_insert_erase_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // applies one command to the predicted list and returns the response it gives
   function automatic list_rsp_t list_step(input list_req_t r);
      list_rsp_t o;
      int        i;
      o = '0;
      o.status = ST_OK;
      case (r.cmd)
         CMD_APPEND: begin
            if (list_len >= DEPTH) begin
               o.status = ST_FULL;
            end else begin
               list_words[list_len] = r.value;
               list_len++;
            end
         end
         CMD_INSERT: begin
            // fullness wins over a bad position
            if (list_len >= DEPTH) begin
               o.status = ST_FULL;
            end else if (r.pos > list_len) begin
               o.status = ST_RANGE;
            end else begin
               for (i = list_len; i > r.pos; i--) list_words[i] = list_words[i-1];
               list_words[r.pos] = r.value;
               list_len++;
            end
         end
         CMD_POP: begin
            if (list_len == 0) o.status = ST_EMPTY;
            else list_len--;
         end
         CMD_ERASE: begin
            if (r.pos >= list_len) begin
               o.status = ST_RANGE;
            end else begin
               for (i = r.pos + 1; i < list_len; i++) list_words[i-1] = list_words[i];
               list_len--;
            end
         end
         CMD_READ: begin
            if (r.pos >= list_len) o.status = ST_RANGE;
            else o.rdata = list_words[r.pos];
         end
         default: ;
      endcase
      o.count = list_len[COUNT_W-1:0];
      return o;
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      if ($urandom_range(99) < 12) begin
         case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
         endcase
      end
      return $urandom;
   endfunction

   // mostly well-formed commands that fill the list up and drain it again
   function automatic list_req_t next_random_req();
      list_req_t r;
      int        roll;
      int        top;
      if (list_len == DEPTH) filling = 1'b0;
      else if (list_len == 0) filling = 1'b1;
      else if ($urandom_range(99) < 3) filling = ~filling;
      top = (list_len == 0) ? 0 : list_len - 1;
      r.value = pick_word();
      r.pos   = POS_W'($urandom_range(top));
      roll    = $urandom_range(99);
      if (roll < 6) begin
         r.cmd = CMD_W'($urandom_range(7));
         r.pos = POS_W'($urandom_range(31));
      end else if (filling) begin
         if (roll < 40) r.cmd = CMD_APPEND;
         else if (roll < 70) begin
            r.cmd = CMD_INSERT;
            r.pos = POS_W'($urandom_range(list_len));
         end else if (roll < 78) r.cmd = CMD_ERASE;
         else if (roll < 83) r.cmd = CMD_POP;
         else r.cmd = CMD_READ;
      end else begin
         if (roll < 40) r.cmd = CMD_ERASE;
         else if (roll < 58) r.cmd = CMD_POP;
         else if (roll < 66) r.cmd = CMD_APPEND;
         else if (roll < 72) r.cmd = CMD_INSERT;
         else r.cmd = CMD_READ;
      end
      return r;
   endfunction

   task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                          input logic [WORD_W-1:0] value, input int reps, input bit typed,
                          input logic [WORD_W-1:0] rd, input logic [COUNT_W-1:0] cnt,
                          input logic [STATUS_W-1:0] st);
      dir_row_t row;
      row.req   = '{value: value, pos: pos, cmd: cmd};
      row.reps  = reps;
      row.typed = typed;
      row.want  = '{pad: 1'b0, status: st, count: cnt, rdata: rd};
      dir_rows  = {dir_rows, row};
   endtask

   task automatic send_req(input list_req_t r, input bit typed, input list_rsp_t want);
      list_rsp_t guess;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= r;
      do @(posedge clock); while (!req_tready);
      guess = list_step(r);
      pending_rsp = {pending_rsp, (typed ? want : guess)};
   endtask

   task automatic drain_pending();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   // response checker and receiver stalls
   always @(posedge clock) begin : rsp_check
      list_rsp_t got;
      list_rsp_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response %h", $time, rsp_tdata);
         end else begin
            want = pending_rsp.pop_front();
            if (got.rdata !== want.rdata) begin
               mismatches++;
               $display("%0t: read_data expected %h actual %h", $time, want.rdata, got.rdata);
            end
            if (got.count !== want.count) begin
               mismatches++;
               $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                        got.count);
            end
            if (got.status !== want.status) begin
               mismatches++;
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        got.status);
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress, %0d responses outstanding", $time, pending_rsp.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int        phase;
      int        k;
      list_req_t r;
      list_rsp_t none;
      int        idle_of [4];
      int        stall_of [4];

      idle_of  = '{0, 71, 0, 8};
      stall_of = '{0, 0, 71, 8};
      none = '0;
      // empty list corner cases, then two entries read back
      add_row(CMD_POP,      0,  32'h0,         1, 1, 32'h0,         0,  ST_EMPTY);
      add_row(CMD_ERASE,    0,  32'h0,         1, 1, 32'h0,         0,  ST_RANGE);
      add_row(CMD_READ,     0,  32'h0,         1, 1, 32'h0,         0,  ST_RANGE);
      add_row(CMD_INSERT,   1,  32'h1234_5678, 1, 1, 32'h0,         0,  ST_RANGE);
      add_row(CMD_SPARE_LO, 0,  32'h0,         1, 1, 32'h0,         0,  ST_OK);
      add_row(CMD_SPARE_HI, 31, 32'hffff_ffff, 1, 1, 32'h0,         0,  ST_OK);
      add_row(CMD_INSERT,   0,  32'h8000_0000, 1, 1, 32'h0,         1,  ST_OK);
      add_row(CMD_APPEND,   0,  32'h7fff_ffff, 1, 1, 32'h0,         2,  ST_OK);
      add_row(CMD_READ,     0,  32'h0,         1, 1, 32'h8000_0000, 2,  ST_OK);
      add_row(CMD_READ,     1,  32'h0,         1, 1, 32'h7fff_ffff, 2,  ST_OK);
      add_row(CMD_READ,     2,  32'h0,         1, 1, 32'h0,         2,  ST_RANGE);
      // insert at the end, in the middle, then erase the head
      add_row(CMD_INSERT,   2,  32'hffff_ffff, 1, 0, 32'h0,         0,  ST_OK);
      add_row(CMD_INSERT,   1,  32'h0,         1, 0, 32'h0,         0,  ST_OK);
      add_row(CMD_ERASE,    0,  32'h0,         1, 0, 32'h0,         0,  ST_OK);
      add_row(CMD_READ,     31, 32'h0,         1, 1, 32'h0,         3,  ST_RANGE);
      // fill up and poke the full list
      add_row(CMD_APPEND,   0,  32'h5a5a_0000, 13, 0, 32'h0,        0,  ST_OK);
      add_row(CMD_APPEND,   0,  32'h1,         1, 1, 32'h0,         16, ST_FULL);
      add_row(CMD_INSERT,   0,  32'h2,         1, 1, 32'h0,         16, ST_FULL);
      add_row(CMD_INSERT,   31, 32'h3,         1, 1, 32'h0,         16, ST_FULL);
      add_row(CMD_READ,     15, 32'h0,         1, 0, 32'h0,         0,  ST_OK);
      add_row(CMD_READ,     16, 32'h0,         1, 1, 32'h0,         16, ST_RANGE);
      add_row(CMD_ERASE,    15, 32'h0,         1, 0, 32'h0,         0,  ST_OK);
      add_row(CMD_ERASE,    0,  32'h0,         1, 0, 32'h0,         0,  ST_OK);
      add_row(CMD_ERASE,    16, 32'h0,         1, 1, 32'h0,         14, ST_RANGE);
      add_row(CMD_POP,      0,  32'h0,         3, 0, 32'h0,         0,  ST_OK);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         for (k = 0; k < dir_rows[i].reps; k++) begin
            r = dir_rows[i].req;
            r.value = r.value + k;
            send_req(r, dir_rows[i].typed, dir_rows[i].want);
         end
      end

      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_of[phase];
         stall_pct     = stall_of[phase];
         for (k = 0; k < RAND_ITEMS; k++) send_req(next_random_req(), 1'b0, none);
         // hold off the sender until the block has answered everything
         if (phase == 1) drain_pending();
      end

      drain_pending();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
